>>> design/complex_integer_divide_rounded_core_macros.svh
// assertion macros shared by the checker of the complex divider
// no dependencies
`ifndef COMPLEX_INTEGER_DIVIDE_ROUNDED_CORE_MACROS_SVH
`define COMPLEX_INTEGER_DIVIDE_ROUNDED_CORE_MACROS_SVH

// overlapping implication, checked on every rising edge out of reset
`define CIDR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("complex divider check failed");

// next-cycle implication
`define CIDR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("complex divider check failed");

`endif

>>> design/cidr_pkg.sv
// shared constants and helpers of the rounded complex divider
// no dependencies
package cidr_pkg;

  // stages ahead of the pipelined restoring divide: input, products, sums, magnitudes
  localparam int unsigned PRE_STAGES = 4;

  // edges from item accepted to result strobe sampled
  function automatic int unsigned cidr_latency(input int unsigned w);
    return PRE_STAGES + (w + 1) + 1;
  endfunction

endpackage

>>> design/complex_integer_divide_rounded_core.sv
// Rounded complex integer divider (a+jb)/(c+jd), fully pipelined, one item per clock
// while busy is low. Uses cidr_pkg. Four stages register the inputs and build the
// products, sums and magnitudes, DATA_WIDTH+1 restoring divide stages each resolve one
// quotient bit of both parts, and one stage rounds half away from zero and saturates. busy
// is high during reset and in the first cycle after it and low otherwise, so start may be
// held every cycle.
// out_valid strobes for exactly one cycle per item in accept order; the receiver cannot
// stall. A zero denominator gives zero parts with out_divide_by_zero set.
module complex_integer_divide_rounded_core #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_num_re,
  input  logic signed [DATA_WIDTH-1:0] in_num_im,
  input  logic signed [DATA_WIDTH-1:0] in_den_re,
  input  logic signed [DATA_WIDTH-1:0] in_den_im,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_quot_re,
  output logic signed [DATA_WIDTH-1:0] out_quot_im,
  output logic                         out_divide_by_zero,
  output logic                         out_saturated
);
  import cidr_pkg::*;

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned PW  = 2 * W;       // product width
  localparam int unsigned NW  = 2 * W + 1;   // numerator sum / magnitude width
  localparam int unsigned CW  = 3 * W + 2;   // compare width for shifted divisor
  localparam int unsigned QW  = W + 1;       // quotient bits kept
  localparam int unsigned NST = W + 1;       // divide stages

  logic busy_r;
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end
  assign busy = busy_r;

  // stage 1: input registers
  logic                v1_r;
  logic signed [W-1:0] a1_r, b1_r, c1_r, d1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start && !busy_r;
    a1_r <= in_num_re;
    b1_r <= in_num_im;
    c1_r <= in_den_re;
    d1_r <= in_den_im;
  end

  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] ac2_r, bd2_r, bc2_r, ad2_r, cc2_r, dd2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    ac2_r <= a1_r * c1_r;
    bd2_r <= b1_r * d1_r;
    bc2_r <= b1_r * c1_r;
    ad2_r <= a1_r * d1_r;
    cc2_r <= c1_r * c1_r;
    dd2_r <= d1_r * d1_r;
  end

  // stage 3: sums
  logic                 v3_r;
  logic signed [NW-1:0] re3_r, im3_r;
  logic [PW-1:0]        den3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    re3_r  <= NW'(ac2_r) + NW'(bd2_r);
    im3_r  <= NW'(bc2_r) - NW'(ad2_r);
    den3_r <= PW'(cc2_r) + PW'(dd2_r);
  end

  // divide pipeline, index 0 is the magnitude stage, index j+1 follows divide step j
  logic          dv_r     [0:NST];
  logic          neg_re_r [0:NST];
  logic          neg_im_r [0:NST];
  logic          ovf_re_r [0:NST];
  logic          ovf_im_r [0:NST];
  logic          dz_r     [0:NST];
  logic [NW-1:0] rem_re_r [0:NST];
  logic [NW-1:0] rem_im_r [0:NST];
  logic [QW-1:0] q_re_r   [0:NST];
  logic [QW-1:0] q_im_r   [0:NST];
  logic [PW-1:0] den_r    [0:NST];

  // stage 4: magnitudes, zero check, range pre-check
  logic [NW-1:0] mag_re_nxt, mag_im_nxt;
  logic [CW-1:0] den_top_nxt;
  always_comb begin
    mag_re_nxt  = re3_r[NW-1] ? NW'(-re3_r) : NW'(re3_r);
    mag_im_nxt  = im3_r[NW-1] ? NW'(-im3_r) : NW'(im3_r);
    den_top_nxt = CW'(den3_r) << QW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= v3_r;
    neg_re_r[0] <= re3_r[NW-1];
    neg_im_r[0] <= im3_r[NW-1];
    // quotient would not fit the kept bits
    ovf_re_r[0] <= CW'(mag_re_nxt) >= den_top_nxt;
    ovf_im_r[0] <= CW'(mag_im_nxt) >= den_top_nxt;
    dz_r[0]     <= den3_r == '0;
    rem_re_r[0] <= mag_re_nxt;
    rem_im_r[0] <= mag_im_nxt;
    q_re_r[0]   <= '0;
    q_im_r[0]   <= '0;
    den_r[0]    <= den3_r;
  end

  // restoring divide, one quotient bit per stage from the top down
  for (genvar j = 0; j < NST; j++) begin : g_div
    localparam int unsigned SH = W - j;
    logic [CW-1:0] dsh_nxt;
    logic          take_re_nxt, take_im_nxt;
    logic [CW-1:0] sub_re_nxt, sub_im_nxt;
    always_comb begin
      dsh_nxt     = CW'(den_r[j]) << SH;
      take_re_nxt = CW'(rem_re_r[j]) >= dsh_nxt;
      take_im_nxt = CW'(rem_im_r[j]) >= dsh_nxt;
      sub_re_nxt  = CW'(rem_re_r[j]) - dsh_nxt;
      sub_im_nxt  = CW'(rem_im_r[j]) - dsh_nxt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else        dv_r[j+1] <= dv_r[j];
      neg_re_r[j+1] <= neg_re_r[j];
      neg_im_r[j+1] <= neg_im_r[j];
      ovf_re_r[j+1] <= ovf_re_r[j];
      ovf_im_r[j+1] <= ovf_im_r[j];
      dz_r[j+1]     <= dz_r[j];
      den_r[j+1]    <= den_r[j];
      rem_re_r[j+1] <= take_re_nxt ? sub_re_nxt[NW-1:0] : rem_re_r[j];
      rem_im_r[j+1] <= take_im_nxt ? sub_im_nxt[NW-1:0] : rem_im_r[j];
      q_re_r[j+1]   <= {q_re_r[j][QW-2:0], take_re_nxt};
      q_im_r[j+1]   <= {q_im_r[j][QW-2:0], take_im_nxt};
    end
  end

  // round half away from zero, clamp; returns {clamped, value}
  function automatic logic [W:0] round_sat(input logic          neg,
                                           input logic          ovf,
                                           input logic [QW-1:0] q,
                                           input logic [NW-1:0] rem,
                                           input logic [PW-1:0] den);
    logic          up;
    logic [W+1:0]  qr;
    logic [W+1:0]  limit;
    logic          sat;
    logic [W-1:0]  mag;
    up    = (CW'(rem) << 1) >= CW'(den);
    qr    = (W+2)'(q) + (W+2)'(up);
    limit = neg ? ((W+2)'(1) << (W - 1)) : (((W+2)'(1) << (W - 1)) - (W+2)'(1));
    sat   = ovf || (qr > limit);
    mag   = sat ? limit[W-1:0] : qr[W-1:0];
    return {sat, neg ? W'(-mag) : mag};
  endfunction

  logic [W:0] fin_re_nxt, fin_im_nxt;
  always_comb begin
    fin_re_nxt = round_sat(neg_re_r[NST], ovf_re_r[NST], q_re_r[NST], rem_re_r[NST],
                           den_r[NST]);
    fin_im_nxt = round_sat(neg_im_r[NST], ovf_im_r[NST], q_im_r[NST], rem_im_r[NST],
                           den_r[NST]);
  end

  logic                out_valid_r;
  logic signed [W-1:0] quot_re_r, quot_im_r;
  logic                dz_out_r, sat_out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_r[NST];
    if (dz_r[NST]) begin
      quot_re_r <= '0;
      quot_im_r <= '0;
      sat_out_r <= 1'b0;
    end else begin
      quot_re_r <= fin_re_nxt[W-1:0];
      quot_im_r <= fin_im_nxt[W-1:0];
      sat_out_r <= fin_re_nxt[W] || fin_im_nxt[W];
    end
    dz_out_r <= dz_r[NST];
  end

  assign out_valid          = out_valid_r;
  assign out_quot_re        = quot_re_r;
  assign out_quot_im        = quot_im_r;
  assign out_divide_by_zero = dz_out_r;
  assign out_saturated      = sat_out_r;

endmodule

>>> design/cidr_checker.sv
// port-level checks of the complex divider, bound to the top level
// uses cidr_pkg and complex_integer_divide_rounded_core_macros.svh
`include "complex_integer_divide_rounded_core_macros.svh"

module cidr_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic signed [DATA_WIDTH-1:0] out_quot_re,
  input logic signed [DATA_WIDTH-1:0] out_quot_im,
  input logic                         out_divide_by_zero,
  input logic                         out_saturated
);
  import cidr_pkg::*;

  localparam int unsigned LAT = cidr_latency(DATA_WIDTH);
  localparam logic signed [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] QMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic fire;
  assign fire = start && !busy;

  `CIDR_ASSERT_IMP(a_no_phantom, clk, rst_n, out_valid, $past(fire, LAT))
  `CIDR_ASSERT_IMP(a_no_loss, clk, rst_n, fire, ##LAT out_valid)
  `CIDR_ASSERT_IMP(a_dz_zero, clk, rst_n, out_valid && out_divide_by_zero,
                   out_quot_re == '0 && out_quot_im == '0 && !out_saturated)
  `CIDR_ASSERT_IMP(a_sat_rail, clk, rst_n, out_valid && out_saturated,
                   out_quot_re == QMAX || out_quot_re == QMIN ||
                   out_quot_im == QMAX || out_quot_im == QMIN)

endmodule

bind complex_integer_divide_rounded_core cidr_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_cidr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_quot_re       (out_quot_re),
  .out_quot_im       (out_quot_im),
  .out_divide_by_zero(out_divide_by_zero),
  .out_saturated     (out_saturated)
);
